// ===== rtl/wcfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcfe_pkg
// Shared constants of the word clock frame encoder: the word list with the
// letter spans on the 11x10 grid and the grid-to-driver wiring.
// ----------------------------------------------------------------------------
package wcfe_pkg;

   localparam int GRID_COLS  = 11;
   localparam int GRID_ROWS  = 10;
   localparam int HOUR_WORDS = 12;

   // word indexes; the twelve hour words follow from WORD_HOUR0 in hour order
   localparam int WORD_ES      = 0;
   localparam int WORD_IST     = 1;
   localparam int WORD_FUENF   = 2;
   localparam int WORD_ZEHN    = 3;
   localparam int WORD_ZWANZIG = 4;
   localparam int WORD_VIERTEL = 5;
   localparam int WORD_NACH    = 6;
   localparam int WORD_VOR     = 7;
   localparam int WORD_HALB    = 8;
   localparam int WORD_UHR     = 9;
   localparam int WORD_EIN     = 10;
   localparam int WORD_HOUR0   = 11;
   localparam int WORD_COUNT   = WORD_HOUR0 + HOUR_WORDS;

   // two drivers of eight rows each, eight columns a row
   localparam int FRAME_LINES = 16;
   localparam int LINE_BITS   = 8;

   typedef logic [WORD_COUNT-1:0]             word_set_type;
   typedef logic [FRAME_LINES-1:0][LINE_BITS-1:0] frame_type;

   typedef struct packed {
      logic [3:0] y;
      logic [3:0] x;
      logic [2:0] len;
   } span_type;

   function automatic span_type word_span(input int w);
      span_type s;
      s = '0;
      case (w)
         WORD_ES:          s = '{y: 4'd0, x: 4'd0, len: 3'd2};
         WORD_IST:         s = '{y: 4'd0, x: 4'd3, len: 3'd3};
         WORD_FUENF:       s = '{y: 4'd0, x: 4'd7, len: 3'd4};
         WORD_ZEHN:        s = '{y: 4'd1, x: 4'd0, len: 3'd4};
         WORD_ZWANZIG:     s = '{y: 4'd1, x: 4'd4, len: 3'd7};
         WORD_VIERTEL:     s = '{y: 4'd2, x: 4'd4, len: 3'd7};
         WORD_NACH:        s = '{y: 4'd3, x: 4'd2, len: 3'd4};
         WORD_VOR:         s = '{y: 4'd3, x: 4'd6, len: 3'd3};
         WORD_HALB:        s = '{y: 4'd4, x: 4'd0, len: 3'd4};
         WORD_UHR:         s = '{y: 4'd9, x: 4'd8, len: 3'd3};
         WORD_EIN:         s = '{y: 4'd5, x: 4'd2, len: 3'd3};
         WORD_HOUR0 + 0:   s = '{y: 4'd4, x: 4'd5, len: 3'd5};
         WORD_HOUR0 + 1:   s = '{y: 4'd5, x: 4'd2, len: 3'd4};
         WORD_HOUR0 + 2:   s = '{y: 4'd5, x: 4'd0, len: 3'd4};
         WORD_HOUR0 + 3:   s = '{y: 4'd6, x: 4'd1, len: 3'd4};
         WORD_HOUR0 + 4:   s = '{y: 4'd7, x: 4'd7, len: 3'd4};
         WORD_HOUR0 + 5:   s = '{y: 4'd6, x: 4'd7, len: 3'd4};
         WORD_HOUR0 + 6:   s = '{y: 4'd9, x: 4'd1, len: 3'd5};
         WORD_HOUR0 + 7:   s = '{y: 4'd5, x: 4'd5, len: 3'd6};
         WORD_HOUR0 + 8:   s = '{y: 4'd8, x: 4'd1, len: 3'd4};
         WORD_HOUR0 + 9:   s = '{y: 4'd7, x: 4'd3, len: 3'd4};
         WORD_HOUR0 + 10:  s = '{y: 4'd8, x: 4'd5, len: 3'd4};
         WORD_HOUR0 + 11:  s = '{y: 4'd7, x: 4'd0, len: 3'd3};
         default:          s = '0;
      endcase
      return s;
   endfunction

   function automatic logic span_covers(input int w, input int y, input int x);
      span_type s;
      s = word_span(w);
      return (y == int'(s.y)) && (x >= int'(s.x)) && (x < int'(s.x) + int'(s.len));
   endfunction

   // frame line {chip, row} of grid cell (y, x)
   function automatic logic [3:0] cell_line(input int y, input int x);
      logic       chip;
      logic [2:0] row;
      chip = (y >= 2) && (x < 8);
      if (y == 0)
         row = 3'((x % 4) * 2 + 1);
      else if (y == 1)
         row = 3'((x % 4) * 2);
      else
         row = 3'(9 - y);
      return {chip, row};
   endfunction

   function automatic logic [2:0] cell_col(input int y, input int x);
      if (y < 2)
         return 3'(4 + x / 4);
      else
         return 3'((x + 1) % 8);
   endfunction

endpackage

// ===== rtl/word_clock_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_clock_frame_encoder_core
// Turns a time of day into the sixteen row patterns of a German word clock.
// ----------------------------------------------------------------------------
// usage
//   req_ channel carries one time of day (hour, minute, second) per transfer
//   rsp_ channel returns the frame as sixteen transfers: chip 0 rows 0..7,
//   then chip 1 rows 0..7; rsp_last_row marks the sixteenth
//   a time is held in an input register, decoded into a frame register when
//   the row sequencer is free, and rows leave through an output register
//   throughput: one row per cycle while the receiver is ready, set by the
//   single row sequencer; the next time is taken in while a frame streams
//   out and its first row follows the last row of the previous frame
//   directly
//   a stalled receiver freezes the output register and the row counter; the
//   input register still takes one more time, then req_ready drops
//   reset empties the input, frame and output stages; no frame is emitted
// ----------------------------------------------------------------------------
module word_clock_frame_encoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [4:0] req_hour_of_day,
   input  logic [5:0] req_minute_of_hour,
   input  logic [5:0] req_second_of_minute,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matrix_chip,
   output logic [2:0] rsp_matrix_row,
   output logic [7:0] rsp_row_pattern,
   output logic       rsp_last_row
);
   import wcfe_pkg::*;

   localparam logic [3:0] LAST_LINE = 4'(FRAME_LINES - 1);

   // input register
   logic       hold_valid_ff, hold_valid_in;
   logic [4:0] hold_hour_ff;
   logic [5:0] hold_minute_ff;
   logic [5:0] hold_second_ff;

   // frame register and row sequencer
   frame_type  frame_ff;
   logic       active_ff, active_in;
   logic [3:0] line_ff, line_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_chip_ff;
   logic [2:0] rsp_row_ff;
   logic [7:0] rsp_pattern_ff;
   logic       rsp_last_ff;

   word_set_type words;
   frame_type    frame_next;
   logic         step;
   logic         finishing;
   logic         load;
   logic         req_xfer;

   wcfe_phrase u_phrase (
      .hour_of_day      (hold_hour_ff),
      .minute_of_hour   (hold_minute_ff),
      .second_of_minute (hold_second_ff),
      .words            (words)
   );

   wcfe_frame_map u_frame_map (
      .words (words),
      .frame (frame_next)
   );

   // a row of the active frame moves into the output register whenever that register frees up
   assign step      = active_ff && (!rsp_valid_ff || rsp_ready);
   assign finishing = step && (line_ff == LAST_LINE);
   // a held time becomes the new frame once the sequencer is idle or ending
   assign load      = hold_valid_ff && (!active_ff || finishing);
   // no transfer is taken while reset is held
   assign req_ready = !reset && (!hold_valid_ff || load);
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_xfer)
         hold_valid_in = 1'b1;
      else if (load)
         hold_valid_in = 1'b0;

      active_in = active_ff;
      if (load)
         active_in = 1'b1;
      else if (finishing)
         active_in = 1'b0;

      line_in = line_ff;
      if (load)
         line_in = '0;
      else if (step)
         line_in = line_ff + 4'd1;

      rsp_valid_in = rsp_valid_ff;
      if (step)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         active_ff     <= 1'b0;
         line_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         active_ff     <= active_in;
         line_ff       <= line_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         hold_hour_ff   <= req_hour_of_day;
         hold_minute_ff <= req_minute_of_hour;
         hold_second_ff <= req_second_of_minute;
      end
      if (load)
         frame_ff <= frame_next;
      if (step) begin
         rsp_chip_ff    <= line_ff[3];
         rsp_row_ff     <= line_ff[2:0];
         rsp_pattern_ff <= frame_ff[line_ff];
         rsp_last_ff    <= (line_ff == LAST_LINE);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_matrix_chip = rsp_chip_ff;
   assign rsp_matrix_row  = rsp_row_ff;
   assign rsp_row_pattern = rsp_pattern_ff;
   assign rsp_last_row    = rsp_last_ff;

endmodule

// ===== rtl/wcfe_phrase.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcfe_phrase
// Rounds the time to five minutes and picks the set of words to light.
// ----------------------------------------------------------------------------
module wcfe_phrase (
   input  logic [4:0]                hour_of_day,
   input  logic [5:0]                minute_of_hour,
   input  logic [5:0]                second_of_minute,
   output wcfe_pkg::word_set_type    words
);
   import wcfe_pkg::*;

   localparam logic [5:0] SECOND_HALF   = 6'd30;
   localparam logic [5:0] HOURS_PER_DAY = 6'd24;
   localparam logic [4:0] HOURS_HALF    = 5'd12;
   localparam logic [4:0] LAST_HOUR     = 5'd23;

   logic       s30;
   logic [5:0] hour_plus;
   logic [4:0] next_hour;
   logic [4:0] sel_hour;
   logic [4:0] hour_mod;
   logic       plural;

   function automatic logic past(input logic [5:0] m, input logic s_half,
                                 input logic [5:0] k);
      return (m > k) || ((m >= k) && s_half);
   endfunction

   assign s30       = second_of_minute >= SECOND_HALF;
   assign hour_plus = {1'b0, hour_of_day} + 6'd1;
   assign next_hour = (hour_plus >= HOURS_PER_DAY) ? 5'(hour_plus - HOURS_PER_DAY)
                                                   : hour_plus[4:0];

   always_comb begin
      words    = '0;
      sel_hour = next_hour;
      plural   = 1'b1;
      words[WORD_ES]  = 1'b1;
      words[WORD_IST] = 1'b1;

      if (past(minute_of_hour, s30, 6'd57) || (minute_of_hour < 6'd3 && !s30) ||
          minute_of_hour < 6'd2) begin
         sel_hour = (minute_of_hour > 6'd2) ? next_hour : hour_of_day;
         plural   = 1'b0;
         words[WORD_UHR] = 1'b1;
      end else if (past(minute_of_hour, s30, 6'd52)) begin
         words[WORD_FUENF] = 1'b1;
         words[WORD_VOR]   = 1'b1;
      end else if (past(minute_of_hour, s30, 6'd47)) begin
         words[WORD_ZEHN] = 1'b1;
         words[WORD_VOR]  = 1'b1;
      end else if (past(minute_of_hour, s30, 6'd42)) begin
         words[WORD_VIERTEL] = 1'b1;
         words[WORD_VOR]     = 1'b1;
      end else if (past(minute_of_hour, s30, 6'd37)) begin
         words[WORD_ZWANZIG] = 1'b1;
         words[WORD_VOR]     = 1'b1;
      end else if (past(minute_of_hour, s30, 6'd32)) begin
         words[WORD_FUENF] = 1'b1;
         words[WORD_NACH]  = 1'b1;
         words[WORD_HALB]  = 1'b1;
      end else if (past(minute_of_hour, s30, 6'd27)) begin
         words[WORD_HALB] = 1'b1;
      end else if (past(minute_of_hour, s30, 6'd22)) begin
         words[WORD_FUENF] = 1'b1;
         words[WORD_VOR]   = 1'b1;
         words[WORD_HALB]  = 1'b1;
      end else if (past(minute_of_hour, s30, 6'd17)) begin
         words[WORD_ZWANZIG] = 1'b1;
         words[WORD_NACH]    = 1'b1;
         sel_hour            = hour_of_day;
      end else if (past(minute_of_hour, s30, 6'd12)) begin
         words[WORD_VIERTEL] = 1'b1;
      end else if (past(minute_of_hour, s30, 6'd7)) begin
         words[WORD_ZEHN] = 1'b1;
         words[WORD_NACH] = 1'b1;
         sel_hour         = hour_of_day;
      end else begin
         words[WORD_FUENF] = 1'b1;
         words[WORD_NACH]  = 1'b1;
         sel_hour          = hour_of_day;
      end

      hour_mod = (sel_hour >= HOURS_HALF) ? sel_hour - HOURS_HALF : sel_hour;

      // hours past the end of the day light no hour word
      if (sel_hour <= LAST_HOUR) begin
         if (hour_mod == 5'd1 && !plural)
            words[WORD_EIN] = 1'b1;
         else
            words[WORD_HOUR0 + int'(hour_mod)] = 1'b1;
      end
   end

endmodule

// ===== rtl/wcfe_frame_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcfe_frame_map
// Lights the letters of the chosen words and routes each grid cell to its
// driver chip, row and column.
// ----------------------------------------------------------------------------
module wcfe_frame_map (
   input  wcfe_pkg::word_set_type words,
   output wcfe_pkg::frame_type     frame
);
   import wcfe_pkg::*;

   always_comb begin
      logic lit;
      frame = '0;
      for (int y = 0; y < GRID_ROWS; y++) begin
         for (int x = 0; x < GRID_COLS; x++) begin
            lit = 1'b0;
            for (int w = 0; w < WORD_COUNT; w++) begin
               if (words[w] && span_covers(w, y, x))
                  lit = 1'b1;
            end
            frame[cell_line(y, x)][cell_col(y, x)] =
               frame[cell_line(y, x)][cell_col(y, x)] | lit;
         end
      end
   end

endmodule

// ===== tb/tb_word_clock_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_word_clock_frame_encoder_core
// Checks the word clock frame encoder against an independent model of the
// phrase choice and the grid-to-driver wiring. A queue of times feeds a
// valid/ready driver, every accepted time yields sixteen expected rows, and a
// monitor compares each row transfer with the oldest expected row. Both
// channels stall at random, apart from one stretch that runs at full rate.
// ----------------------------------------------------------------------------
module tb_word_clock_frame_encoder_core;

   // words of the phrase, hour words are looked up by hour mod 12
   typedef enum int {
      WORD_ES, WORD_IST, WORD_FUENF, WORD_ZEHN, WORD_ZWANZIG, WORD_VIERTEL,
      WORD_NACH, WORD_VOR, WORD_HALB, WORD_UHR, WORD_EIN
   } phrase_word_type;

   typedef struct packed {
      bit [3:0] y;
      bit [3:0] x;
      bit [2:0] len;
   } letter_span_type;

   typedef struct packed {
      bit [4:0] hour;
      bit [5:0] minute;
      bit [5:0] sec;
   } clock_time_type;

   typedef struct packed {
      bit       chip;
      bit [2:0] row;
      bit [7:0] pattern;
      bit       last;
   } frame_row_type;

   localparam int ROWS_PER_FRAME = 16;
   localparam int IDLE_PERCENT   = 21;
   localparam int RANDOM_TIMES   = 324;
   // full-rate stretch, in clock cycles after reset
   localparam int STEADY_FROM    = 1500;
   localparam int STEADY_TO      = 3000;
   localparam int DRAIN_CYCLES   = 20;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [4:0] req_hour_of_day = '0;
   logic [5:0] req_minute_of_hour = '0;
   logic [5:0] req_second_of_minute = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_matrix_chip;
   logic [2:0] rsp_matrix_row;
   logic [7:0] rsp_row_pattern;
   logic       rsp_last_row;

   clock_time_type pending_times[$];
   frame_row_type  expected_rows[$];
   bit [7:0]       lit_lines[ROWS_PER_FRAME];
   int             mismatch_count = 0;
   int             cycle_count = 0;

   word_clock_frame_encoder_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_hour_of_day      (req_hour_of_day),
      .req_minute_of_hour   (req_minute_of_hour),
      .req_second_of_minute (req_second_of_minute),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_matrix_chip      (rsp_matrix_chip),
      .rsp_matrix_row       (rsp_matrix_row),
      .rsp_row_pattern      (rsp_row_pattern),
      .rsp_last_row         (rsp_last_row)
   );

   // ------------------------------------------------------------------------
   // frame model
   // ------------------------------------------------------------------------

   function automatic letter_span_type word_letters(phrase_word_type w);
      case (w)
         WORD_ES:      return '{y: 4'd0, x: 4'd0, len: 3'd2};
         WORD_IST:     return '{y: 4'd0, x: 4'd3, len: 3'd3};
         WORD_FUENF:   return '{y: 4'd0, x: 4'd7, len: 3'd4};
         WORD_ZEHN:    return '{y: 4'd1, x: 4'd0, len: 3'd4};
         WORD_ZWANZIG: return '{y: 4'd1, x: 4'd4, len: 3'd7};
         WORD_VIERTEL: return '{y: 4'd2, x: 4'd4, len: 3'd7};
         WORD_NACH:    return '{y: 4'd3, x: 4'd2, len: 3'd4};
         WORD_VOR:     return '{y: 4'd3, x: 4'd6, len: 3'd3};
         WORD_HALB:    return '{y: 4'd4, x: 4'd0, len: 3'd4};
         WORD_UHR:     return '{y: 4'd9, x: 4'd8, len: 3'd3};
         default:      return '{y: 4'd5, x: 4'd2, len: 3'd3};
      endcase
   endfunction

   // zwolf, eins, zwei, drei, vier, funf, sechs, sieben, acht, neun, zehn, elf
   function automatic letter_span_type hour_letters(int idx);
      case (idx)
         0:       return '{y: 4'd4, x: 4'd5, len: 3'd5};
         1:       return '{y: 4'd5, x: 4'd2, len: 3'd4};
         2:       return '{y: 4'd5, x: 4'd0, len: 3'd4};
         3:       return '{y: 4'd6, x: 4'd1, len: 3'd4};
         4:       return '{y: 4'd7, x: 4'd7, len: 3'd4};
         5:       return '{y: 4'd6, x: 4'd7, len: 3'd4};
         6:       return '{y: 4'd9, x: 4'd1, len: 3'd5};
         7:       return '{y: 4'd5, x: 4'd5, len: 3'd6};
         8:       return '{y: 4'd8, x: 4'd1, len: 3'd4};
         9:       return '{y: 4'd7, x: 4'd3, len: 3'd4};
         10:      return '{y: 4'd8, x: 4'd5, len: 3'd4};
         default: return '{y: 4'd7, x: 4'd0, len: 3'd3};
      endcase
   endfunction

   // top two grid rows are interleaved across chip 0, the rest is wired
   // bottom-up with the last three columns folded onto chip 0
   function automatic void light_span(letter_span_type sp);
      int       cx;
      int       cy;
      int       line;
      int       col;
      cy = sp.y;
      for (int i = 0; i < sp.len; i++) begin
         cx = sp.x + i;
         if (cx < 11 && cy < 10) begin
            case (cy)
               0: begin
                  line = 1 + 2 * (cx % 4);
                  col  = 4 + cx / 4;
               end
               1: begin
                  line = 2 * (cx % 4);
                  col  = 4 + cx / 4;
               end
               default: begin
                  line = (cx < 8 ? 8 : 0) + (9 - cy);
                  col  = (cx + 1) % 8;
               end
            endcase
            lit_lines[line][col] = 1'b1;
         end
      end
   endfunction

   function automatic void light_word(phrase_word_type w);
      light_span(word_letters(w));
   endfunction

   // hours past 23 light nothing; hour one reads ein only before uhr
   function automatic void light_hour(int hr, bit before_uhr);
      if (hr <= 23) begin
         if (hr % 12 == 1 && before_uhr)
            light_word(WORD_EIN);
         else
            light_span(hour_letters(hr % 12));
      end
   endfunction

   function automatic bit reached(int mn, int sc, int k);
      return (mn >= k && sc >= 30) || mn > k;
   endfunction

   function automatic void predict_frame(clock_time_type t);
      int hr;
      int mn;
      int sc;
      int next_hr;
      frame_row_type fr;
      hr = t.hour;
      mn = t.minute;
      sc = t.sec;
      next_hr = (hr + 1) % 24;
      for (int i = 0; i < ROWS_PER_FRAME; i++)
         lit_lines[i] = '0;
      light_word(WORD_ES);
      light_word(WORD_IST);
      if (reached(mn, sc, 57) || (mn < 3 && sc < 30) || mn < 2) begin
         // full hour, late minutes already count for the next hour
         light_hour(mn > 2 ? next_hr : hr, 1'b1);
         light_word(WORD_UHR);
      end else if (reached(mn, sc, 52)) begin
         light_word(WORD_FUENF); light_word(WORD_VOR); light_hour(next_hr, 1'b0);
      end else if (reached(mn, sc, 47)) begin
         light_word(WORD_ZEHN); light_word(WORD_VOR); light_hour(next_hr, 1'b0);
      end else if (reached(mn, sc, 42)) begin
         light_word(WORD_VIERTEL); light_word(WORD_VOR); light_hour(next_hr, 1'b0);
      end else if (reached(mn, sc, 37)) begin
         light_word(WORD_ZWANZIG); light_word(WORD_VOR); light_hour(next_hr, 1'b0);
      end else if (reached(mn, sc, 32)) begin
         light_word(WORD_FUENF); light_word(WORD_NACH); light_word(WORD_HALB);
         light_hour(next_hr, 1'b0);
      end else if (reached(mn, sc, 27)) begin
         light_word(WORD_HALB); light_hour(next_hr, 1'b0);
      end else if (reached(mn, sc, 22)) begin
         light_word(WORD_FUENF); light_word(WORD_VOR); light_word(WORD_HALB);
         light_hour(next_hr, 1'b0);
      end else if (reached(mn, sc, 17)) begin
         light_word(WORD_ZWANZIG); light_word(WORD_NACH); light_hour(hr, 1'b0);
      end else if (reached(mn, sc, 12)) begin
         light_word(WORD_VIERTEL); light_hour(next_hr, 1'b0);
      end else if (reached(mn, sc, 7)) begin
         light_word(WORD_ZEHN); light_word(WORD_NACH); light_hour(hr, 1'b0);
      end else begin
         light_word(WORD_FUENF); light_word(WORD_NACH); light_hour(hr, 1'b0);
      end
      // chip 0 rows 0..7, then chip 1 rows 0..7
      for (int i = 0; i < ROWS_PER_FRAME; i++) begin
         fr.chip    = (i >= 8);
         fr.row     = 3'(i % 8);
         fr.pattern = lit_lines[i];
         fr.last    = (i == ROWS_PER_FRAME - 1);
         expected_rows.push_back(fr);
      end
   endfunction

   // ------------------------------------------------------------------------
   // clock, idling and error reporting
   // ------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock)
      if (!reset)
         cycle_count <= cycle_count + 1;

   // one stretch of the run goes without any idle cycles
   function automatic bit idle_roll();
      if (cycle_count >= STEADY_FROM && cycle_count < STEADY_TO)
         return 1'b0;
      return $urandom_range(0, 99) < IDLE_PERCENT;
   endfunction

   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch: %s", $realtime, what);
   endfunction

   function automatic void queue_time(int hr, int mn, int sc);
      clock_time_type t;
      t.hour   = 5'(hr);
      t.minute = 6'(mn);
      t.sec    = 6'(sc);
      pending_times.push_back(t);
   endfunction

   // ------------------------------------------------------------------------
   // request driver: predicts on each accepted transfer, then offers the next
   // ------------------------------------------------------------------------

   always @(posedge clock) begin : drive_times
      clock_time_type accepted;
      clock_time_type upcoming;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            accepted.hour   = req_hour_of_day;
            accepted.minute = req_minute_of_hour;
            accepted.sec    = req_second_of_minute;
            predict_frame(accepted);
         end
         // payload may only change when nothing is on offer or it just left
         if (!req_valid || req_ready) begin
            if (pending_times.size() > 0 && !idle_roll()) begin
               upcoming = pending_times.pop_front();
               req_valid            <= 1'b1;
               req_hour_of_day      <= upcoming.hour;
               req_minute_of_hour   <= upcoming.minute;
               req_second_of_minute <= upcoming.sec;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // row monitor: compares every row transfer with the oldest expected row
   // ------------------------------------------------------------------------

   always @(posedge clock) begin : watch_rows
      frame_row_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rows.size() == 0) begin
            note_mismatch($sformatf("unexpected row chip %0d row %0d pattern %02h last %0b",
                                    rsp_matrix_chip, rsp_matrix_row, rsp_row_pattern,
                                    rsp_last_row));
         end else begin
            want = expected_rows.pop_front();
            if (rsp_matrix_chip !== want.chip || rsp_matrix_row !== want.row ||
                rsp_row_pattern !== want.pattern || rsp_last_row !== want.last)
               note_mismatch($sformatf(
                  "expected chip %0d row %0d pattern %02h last %0b, got %0d %0d %02h %0b",
                  want.chip, want.row, want.pattern, want.last,
                  rsp_matrix_chip, rsp_matrix_row, rsp_row_pattern, rsp_last_row));
         end
      end
      rsp_ready <= !idle_roll();
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------

   initial begin : run_times
      int hr;
      int mn;
      int sc;
      // full hours, hour one and the wrap to midnight
      queue_time(0, 0, 0);
      queue_time(1, 0, 0);
      queue_time(1, 5, 0);
      queue_time(0, 57, 30);
      queue_time(12, 59, 59);
      queue_time(23, 58, 0);
      // second 30 decides the round-up at minute two
      queue_time(12, 2, 29);
      queue_time(12, 2, 30);
      // every phrase, each at its boundary
      queue_time(5, 7, 30);
      queue_time(5, 12, 30);
      queue_time(5, 17, 30);
      queue_time(5, 22, 30);
      queue_time(5, 27, 30);
      queue_time(5, 32, 30);
      queue_time(5, 37, 30);
      queue_time(5, 42, 30);
      queue_time(5, 47, 30);
      queue_time(5, 52, 29);
      queue_time(5, 52, 30);
      // out-of-range fields and the wrap at half past 23
      queue_time(31, 63, 63);
      queue_time(24, 10, 0);
      queue_time(31, 0, 0);
      queue_time(23, 30, 0);
      queue_time(31, 20, 0);
      queue_time(30, 15, 0);
      queue_time(6, 1, 63);

      for (int i = 0; i < RANDOM_TIMES; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            // raw field values, out of range included
            hr = $urandom_range(0, 31);
            mn = $urandom_range(0, 63);
            sc = $urandom_range(0, 63);
         end else begin
            hr = $urandom_range(0, 23);
            mn = $urandom_range(0, 59);
            // lean on the second-30 boundary
            sc = ($urandom_range(0, 2) == 0) ? 28 + $urandom_range(0, 3)
                                             : $urandom_range(0, 59);
         end
         queue_time(hr, mn, sc);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_times.size() != 0 || req_valid || expected_rows.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_rows.size() != 0)
         note_mismatch($sformatf("%0d expected rows never arrived", expected_rows.size()));

      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #1_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/wcfe_pkg.sv
rtl/wcfe_phrase.sv
rtl/wcfe_frame_map.sv
rtl/word_clock_frame_encoder_core.sv
tb/tb_word_clock_frame_encoder_core.sv
